/* rtl/text_mode_console_writer_unit_macros.svh */
// Assertion macros for the text mode console writer.
`ifndef TEXT_MODE_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_UNIT_MACROS_SVH

`ifndef SYNTH
`define TMCW_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmcw assertion failed");
`define TMCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmcw assertion failed");
`else
`define TMCW_ASSERT_IMPL(name, ante, cons)
`define TMCW_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/tmcw_pkg.sv */
// Constants, codes and cell helper for the text mode console writer.
package tmcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);

  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  localparam logic [CHAR_W-1:0]  CHAR_BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [CELL_W-1:0]  CELL_RESET   = 16'h0F20;
  localparam logic [COLOR_W-1:0] FORE_RESET   = 4'd15;
  localparam logic [COLOR_W-1:0] BACK_RESET   = 4'd0;

  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [CHAR_W-1:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage

/* rtl/text_mode_console_writer_unit.sv */
// Text mode console writer: cell buffer memory, cursor and scroll/clear sequencer.
//
//   channel  direction  handshake                       payload
//   in       input      in_valid / in_stall             in_mode, in_char_code, in_row_sel,
//                                                       in_col_sel
//   out      output     out_valid / out_stall           out_cursor_pos, out_cell_data,
//                                                       out_scrolled
//   cfg      input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Put, newline, set cursor and read cell: the accept cycle does the single cell
// write or read; the result register is loaded from S_DONE once the output is free.
// A scroll walks the buffer through the memory's one read and one write port. A
// clear writes one cell a cycle. After reset a clearing pass fills the buffer with
// white-on-black blanks; no item is accepted until it ends, config writes are taken.
// in_stall is high whenever the sequencer is busy or a finished item waits for the
// result register.
`include "text_mode_console_writer_unit_macros.svh"

module text_mode_console_writer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tmcw_pkg::MODE_W-1:0]       in_mode,
  input  logic [tmcw_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tmcw_pkg::ROW_W-1:0]        in_row_sel,
  input  logic [tmcw_pkg::COL_W-1:0]        in_col_sel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tmcw_pkg::POS_W-1:0]        out_cursor_pos,
  output logic [tmcw_pkg::CELL_W-1:0]       out_cell_data,
  output logic                              out_scrolled,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmcw_pkg::PADDR_W-1:0]      paddr,
  input  logic [tmcw_pkg::PDATA_W-1:0]      pwdata,
  output logic [tmcw_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import tmcw_pkg::*;

  typedef enum logic [3:0] {
    S_FILL   = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                init_r, init_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [CELL_W-1:0]   fill_val_r, fill_val_nxt;
  logic [ROW_W-1:0]    cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]    cursor_col_r, cursor_col_nxt;
  logic                res_scrolled_r, res_scrolled_nxt;
  logic                res_read_r, res_read_nxt;
  logic [COLOR_W-1:0]  fore_r, back_r;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]   out_data_r, out_data_nxt;
  logic                out_scrolled_r, out_scrolled_nxt;

  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic [CELL_W-1:0]   rd_data_r;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata;

  logic                in_acc, cfg_we, res_load;
  logic [ADDR_W-1:0]   cur_idx, sel_idx;
  logic                sel_ok, wrap, last_row;
  logic [COL_W:0]      col_inc;
  logic [CELL_W-1:0]   blank;
  logic [CNT_W:0]      src;
  logic [CNT_W-1:0]    wptr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign res_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scrolled_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_BACK) ? PDATA_W'(back_r) : PDATA_W'(fore_r);

  assign cur_idx  = ADDR_W'(cursor_row_r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cursor_col_r);
  assign sel_idx  = ADDR_W'(in_row_sel) * ADDR_W'(SCREEN_COLS) + ADDR_W'(in_col_sel);
  assign sel_ok   = ({1'b0, in_row_sel} < (ROW_W + 1)'(SCREEN_ROWS)) &&
                    ({1'b0, in_col_sel} < (COL_W + 1)'(SCREEN_COLS));
  assign col_inc  = {1'b0, cursor_col_r} + (COL_W + 1)'(1);
  assign wrap     = col_inc >= (COL_W + 1)'(SCREEN_COLS);
  assign last_row = cursor_row_r == ROW_W'(SCREEN_ROWS - 1);
  assign blank    = make_cell(back_r, fore_r, CHAR_BLANK);
  assign src      = {1'b0, ptr_r} + (CNT_W + 1)'(SCREEN_COLS);
  assign wptr     = ptr_r - CNT_W'(1);

  always_comb begin
    state_nxt        = state_r;
    init_nxt         = init_r;
    ptr_nxt          = ptr_r;
    fill_val_nxt     = fill_val_r;
    cursor_row_nxt   = cursor_row_r;
    cursor_col_nxt   = cursor_col_r;
    res_scrolled_nxt = res_scrolled_r;
    res_read_nxt     = res_read_r;
    out_valid_nxt    = out_valid_r;
    out_pos_nxt      = out_pos_r;
    out_data_nxt     = out_data_r;
    out_scrolled_nxt = out_scrolled_r;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = fill_val_r;
        if (ptr_r == CNT_W'(CELL_COUNT - 1)) begin
          ptr_nxt   = '0;
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_DONE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_scrolled_nxt = 1'b0;
          res_read_nxt     = 1'b0;
          state_nxt        = S_DONE;
          case (in_mode)
            MODE_PUT: begin
              if (in_char_code != CHAR_NEWLINE) begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = make_cell(back_r, fore_r, in_char_code);
              end
              if (in_char_code == CHAR_NEWLINE || wrap) begin
                cursor_col_nxt = '0;
                if (last_row) begin
                  res_scrolled_nxt = 1'b1;
                  ptr_nxt          = '0;
                  state_nxt        = S_SCROLL;
                end else begin
                  cursor_row_nxt = cursor_row_r + ROW_W'(1);
                end
              end else begin
                cursor_col_nxt = col_inc[COL_W-1:0];
              end
            end
            MODE_CLEAR: begin
              fill_val_nxt   = blank;
              ptr_nxt        = '0;
              cursor_row_nxt = '0;
              cursor_col_nxt = '0;
              state_nxt      = S_FILL;
            end
            MODE_SET: begin
              if (sel_ok) begin
                cursor_row_nxt = in_row_sel;
                cursor_col_nxt = in_col_sel;
              end
            end
            MODE_READ: begin
              if (sel_ok) begin
                mem_re       = 1'b1;
                mem_raddr    = sel_idx;
                res_read_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCROLL: begin
        if (src < (CNT_W + 1)'(CELL_COUNT)) begin
          mem_re    = 1'b1;
          mem_raddr = src[ADDR_W-1:0];
        end
        if (ptr_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = wptr[ADDR_W-1:0];
          mem_wdata = (src <= (CNT_W + 1)'(CELL_COUNT)) ? rd_data_r : blank;
        end
        if (ptr_r == CNT_W'(CELL_COUNT)) begin
          ptr_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (res_load) begin
          out_valid_nxt    = 1'b1;
          out_pos_nxt      = POS_W'(cur_idx);
          out_data_nxt     = res_read_r ? rd_data_r : '0;
          out_scrolled_nxt = res_scrolled_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      init_r       <= 1'b1;
      ptr_r        <= '0;
      fill_val_r   <= CELL_RESET;
      cursor_row_r <= '0;
      cursor_col_r <= '0;
      out_valid_r  <= 1'b0;
      fore_r       <= FORE_RESET;
      back_r       <= BACK_RESET;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      ptr_r        <= ptr_nxt;
      fill_val_r   <= fill_val_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        if (paddr[2] == REG_BACK) begin
          back_r <= pwdata[COLOR_W-1:0];
        end else begin
          fore_r <= pwdata[COLOR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_scrolled_r <= res_scrolled_nxt;
    res_read_r     <= res_read_nxt;
    out_pos_r      <= out_pos_nxt;
    out_data_r     <= out_data_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  `TMCW_ASSERT_IMPL(a_cursor_in_range, 1'b1, cursor_row_r <= ROW_W'(SCREEN_ROWS - 1))
  `TMCW_ASSERT_IMPL(a_no_rw_collision, mem_we && mem_re, mem_waddr != mem_raddr)
  `TMCW_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE)
  `TMCW_ASSERT_NEXT(a_done_loads_result, res_load, out_valid_r && (state_r == S_IDLE))

endmodule

/* verif/tb_text_mode_console_writer_unit.sv */
// Testbench for the text console writer: directed table plus random items checked against a cell-buffer predictor.
`timescale 1ns / 1ps

module tb_text_mode_console_writer_unit;
  import tmcw_pkg::*;

  localparam logic [PADDR_W-1:0] FORE_ADDR = {REG_FORE, 2'b00};
  localparam logic [PADDR_W-1:0] BACK_ADDR = {REG_BACK, 2'b00};
  localparam int PHASE_ITEMS = 296;
  localparam int DRAIN_CYCLES = 2100;
  localparam longint TIMEOUT_NS = 64'd12 * 64'd12_000_000;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } report_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic              fixed;
    report_t           report;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = MODE_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ROW_W-1:0] in_row_sel = '0;
  logic [COL_W-1:0] in_col_sel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POS_W-1:0] out_cursor_pos;
  logic [CELL_W-1:0] out_cell_data;
  logic out_scrolled;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
  int unsigned cursor_row;
  int unsigned cursor_col;
  logic [COLOR_W-1:0] fore_nib;
  logic [COLOR_W-1:0] back_nib;

  report_t awaited_reports [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  localparam int PLAN_LEN = 25;
  plan_row_t directed_plan [PLAN_LEN] = '{
    '{MODE_READ,  8'h00, 5'd0,  7'd0,   1'b1, '{11'd0,    16'h0F20, 1'b0}},
    '{MODE_READ,  8'hFF, 5'd24, 7'd79,  1'b1, '{11'd0,    16'h0F20, 1'b0}},
    '{MODE_READ,  8'h00, 5'd31, 7'd127, 1'b1, '{11'd0,    16'h0000, 1'b0}},
    '{MODE_READ,  8'h00, 5'd0,  7'd80,  1'b1, '{11'd0,    16'h0000, 1'b0}},
    '{MODE_READ,  8'h00, 5'd25, 7'd0,   1'b1, '{11'd0,    16'h0000, 1'b0}},
    '{MODE_PUT,   8'h41, 5'd31, 7'd127, 1'b1, '{11'd1,    16'h0000, 1'b0}},
    '{MODE_PUT,   8'hFF, 5'd0,  7'd0,   1'b1, '{11'd2,    16'h0000, 1'b0}},
    '{MODE_PUT,   8'h00, 5'd0,  7'd0,   1'b1, '{11'd3,    16'h0000, 1'b0}},
    '{MODE_PUT,   8'h80, 5'd0,  7'd0,   1'b1, '{11'd4,    16'h0000, 1'b0}},
    '{MODE_READ,  8'h00, 5'd0,  7'd3,   1'b1, '{11'd4,    16'h0F80, 1'b0}},
    '{MODE_PUT,   8'h0A, 5'd0,  7'd0,   1'b1, '{11'd80,   16'h0000, 1'b0}},
    '{MODE_SET,   8'h00, 5'd24, 7'd79,  1'b1, '{11'd1999, 16'h0000, 1'b0}},
    '{MODE_PUT,   8'h5A, 5'd0,  7'd0,   1'b1, '{11'd1920, 16'h0000, 1'b1}},
    '{MODE_READ,  8'h00, 5'd23, 7'd79,  1'b1, '{11'd1920, 16'h0F5A, 1'b0}},
    '{MODE_READ,  8'h00, 5'd0,  7'd3,   1'b1, '{11'd1920, 16'h0F20, 1'b0}},
    '{MODE_SET,   8'h00, 5'd25, 7'd0,   1'b1, '{11'd1920, 16'h0000, 1'b0}},
    '{MODE_SET,   8'h00, 5'd0,  7'd80,  1'b1, '{11'd1920, 16'h0000, 1'b0}},
    '{MODE_SET,   8'hFF, 5'd31, 7'd127, 1'b1, '{11'd1920, 16'h0000, 1'b0}},
    '{MODE_PUT,   8'h0A, 5'd0,  7'd0,   1'b1, '{11'd1920, 16'h0000, 1'b1}},
    '{MODE_READ,  8'h00, 5'd22, 7'd79,  1'b1, '{11'd1920, 16'h0F5A, 1'b0}},
    '{MODE_SET,   8'h00, 5'd0,  7'd79,  1'b1, '{11'd79,   16'h0000, 1'b0}},
    '{MODE_PUT,   8'h7E, 5'd5,  7'd5,   1'b0, '{11'd0,    16'h0000, 1'b0}},
    '{MODE_CLEAR, 8'hFF, 5'd31, 7'd127, 1'b1, '{11'd0,    16'h0000, 1'b0}},
    '{MODE_READ,  8'h00, 5'd0,  7'd79,  1'b1, '{11'd0,    16'h0F20, 1'b0}},
    '{MODE_PUT,   8'h0A, 5'd17, 7'd99,  1'b0, '{11'd0,    16'h0000, 1'b0}}
  };

  text_mode_console_writer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_char_code(in_char_code),
    .in_row_sel(in_row_sel),
    .in_col_sel(in_col_sel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_data(out_cell_data),
    .out_scrolled(out_scrolled),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic report_t apply_console_op(input logic [MODE_W-1:0] mode,
                                               input logic [CHAR_W-1:0] ch,
                                               input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    report_t rep;
    int i;
    rep.cell_data = '0;
    rep.scrolled = 1'b0;
    case (mode)
      MODE_PUT: begin
        if (ch != CHAR_NEWLINE) begin
          screen_shadow[cursor_row * SCREEN_COLS + cursor_col] = {back_nib, fore_nib, ch};
          cursor_col++;
        end
        if (ch == CHAR_NEWLINE || cursor_col >= SCREEN_COLS) begin
          cursor_col = 0;
          cursor_row++;
          if (cursor_row >= SCREEN_ROWS) begin
            for (i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
              screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
            for (i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
              screen_shadow[i] = {back_nib, fore_nib, CHAR_BLANK};
            cursor_row = SCREEN_ROWS - 1;
            rep.scrolled = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++)
          screen_shadow[i] = {back_nib, fore_nib, CHAR_BLANK};
        cursor_row = 0;
        cursor_col = 0;
      end
      MODE_SET: begin
        if (row < SCREEN_ROWS && col < SCREEN_COLS) begin
          cursor_row = row;
          cursor_col = col;
        end
      end
      default: begin
        if (row < SCREEN_ROWS && col < SCREEN_COLS)
          rep.cell_data = screen_shadow[row * SCREEN_COLS + col];
      end
    endcase
    rep.cursor_pos = POS_W'(cursor_row * SCREEN_COLS + cursor_col);
    return rep;
  endfunction

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [COLOR_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == FORE_ADDR) fore_nib = val;
    else back_nib = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    write_reg(FORE_ADDR, fg);
    write_reg(BACK_ADDR, bg);
  endtask

  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                         input logic fixed, input report_t fixed_rep);
    report_t rep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_char_code <= ch;
    in_row_sel <= row;
    in_col_sel <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rep = apply_console_op(mode, ch, row, col);
    if (fixed) rep = fixed_rep;
    awaited_reports.push_back(rep);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    report_t exp_rep;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected item: cursor_pos %0d cell_data %h scrolled %0d",
               out_cursor_pos, out_cell_data, out_scrolled);
        mismatches++;
      end else begin
        exp_rep = awaited_reports.pop_front();
        if (out_cursor_pos !== exp_rep.cursor_pos) begin
          $error("cursor_pos expected %0d actual %0d", exp_rep.cursor_pos, out_cursor_pos);
          mismatches++;
        end
        if (out_cell_data !== exp_rep.cell_data) begin
          $error("cell_data expected %h actual %h", exp_rep.cell_data, out_cell_data);
          mismatches++;
        end
        if (out_scrolled !== exp_rep.scrolled) begin
          $error("scrolled expected %0d actual %0d", exp_rep.scrolled, out_scrolled);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("text_mode_console_writer_unit: mismatch");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int pick;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    report_t no_rep;

    no_rep = '0;
    for (n = 0; n < CELL_COUNT; n++) screen_shadow[n] = CELL_RESET;
    cursor_row = 0;
    cursor_col = 0;
    fore_nib = FORE_RESET;
    back_nib = BACK_RESET;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_colors(FORE_RESET, BACK_RESET);

    for (n = 0; n < PLAN_LEN; n++)
      send_op(directed_plan[n].mode, directed_plan[n].char_code, directed_plan[n].row_sel,
              directed_plan[n].col_sel, directed_plan[n].fixed, directed_plan[n].report);
    drain_reports();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_colors(4'd0, 4'd15); end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  set_colors(4'd15, 4'd15); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; set_colors(4'd0, 4'd0); end
        3: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
          set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
        4: begin
          send_idle_pct = 77;
          recv_stall_pct = 77;
          set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; set_colors(4'd15, 4'd0); end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        row = 5'($urandom_range(0, 31));
        col = 7'($urandom_range(0, 127));
        if (pick < 56) begin
          mode = MODE_PUT;
          if ($urandom_range(0, 9) == 0) ch = CHAR_NEWLINE;
        end else if (pick < 58) begin
          mode = MODE_CLEAR;
        end else if (pick < 72) begin
          mode = MODE_SET;
          if ($urandom_range(0, 99) < 85) begin
            row = ($urandom_range(0, 9) < 4) ? 5'($urandom_range(SCREEN_ROWS - 2, SCREEN_ROWS - 1))
                                             : 5'($urandom_range(0, SCREEN_ROWS - 1));
            col = 7'($urandom_range(0, SCREEN_COLS - 1));
          end
        end else begin
          mode = MODE_READ;
          if ($urandom_range(0, 99) < 85) begin
            row = ($urandom_range(0, 1) == 0) ? 5'(cursor_row) : 5'($urandom_range(0, SCREEN_ROWS - 1));
            col = 7'($urandom_range(0, SCREEN_COLS - 1));
          end
        end
        send_op(mode, ch, row, col, 1'b0, no_rep);
      end
      drain_reports();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("text_mode_console_writer_unit: match");
    else
      $display("text_mode_console_writer_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/text_mode_console_writer_unit.sv
verif/tb_text_mode_console_writer_unit.sv
